// File: sv/cipgs_pkg.sv
// ----------------------------------------------------------------------------
// cipgs_pkg
// Shared types and codes of the 2D contact impulse solver.
// ----------------------------------------------------------------------------
package cipgs_pkg;

    typedef enum logic [1:0] {
        CMD_NORMAL   = 2'd0,
        CMD_FRICTION = 2'd1,
        CMD_WRITE    = 2'd2,
        CMD_READ     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_INV_H    = 2'd0,
        CFG_BAUM     = 2'd1,
        CFG_SLOP     = 2'd2,
        CFG_MAX_CORR = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        OP_MUL = 3'd0,
        OP_ADD = 3'd1,
        OP_SUB = 3'd2,
        OP_MAX = 3'd3,
        OP_MIN = 3'd4
    } alu_op_t;

    localparam int unsigned BODY_WORD_W = 160;

endpackage

// File: sv/cipgs_if.sv
// ----------------------------------------------------------------------------
// cipgs_if
// Handshake channels of the contact solver: items, results and config writes.
// ----------------------------------------------------------------------------
interface cipgs_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic [9:0]         body_a;
    logic [9:0]         body_b;
    logic [63:0]        normal_dir;
    logic [63:0]        anchor_a;
    logic [63:0]        anchor_b;
    logic signed [31:0] separation;
    logic signed [31:0] effective_mass;
    logic signed [31:0] accumulated_in;
    logic signed [31:0] normal_accumulated;
    logic signed [31:0] friction_coef;

    modport source (output valid, cmd, body_a, body_b, normal_dir, anchor_a, anchor_b,
                    separation, effective_mass, accumulated_in, normal_accumulated,
                    friction_coef, input ready);
    modport sink (input valid, cmd, body_a, body_b, normal_dir, anchor_a, anchor_b,
                  separation, effective_mass, accumulated_in, normal_accumulated,
                  friction_coef, output ready);
endinterface

interface cipgs_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accumulated_out;
    logic [63:0]        linear_velocity;
    logic signed [31:0] angular_velocity;

    modport source (output valid, accumulated_out, linear_velocity, angular_velocity,
                    input ready);
    modport sink (input valid, accumulated_out, linear_velocity, angular_velocity,
                  output ready);
endinterface

interface cipgs_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: sv/contact_impulse_pgs_solver.sv
// ----------------------------------------------------------------------------
// contact_impulse_pgs_solver
// Projected Gauss-Seidel contact point solver for 2D bodies, Q16.16.
//
//   channel  dir  word
//   items    in   cmd, bodies, normal, anchors, separation, mass, impulses, friction
//   results  out  accumulated_out, linear_velocity, angular_velocity
//   cfg      in   register index, write data
//
// A normal or friction solve runs through two body reads, 51 steps of the shared
// multiply/add unit, two body writes and the result. A read passes through RDA and
// RDB, a write through WRITE. One item at a time; items.ready is low
// until the result word is taken. Reset clears control and loads register
// defaults; the body table holds no reset value. cfg is always ready.
// ----------------------------------------------------------------------------
module contact_impulse_pgs_solver #(
    parameter int BODY_COUNT = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    cipgs_item_if.sink      items,
    cipgs_result_if.source  results,
    cipgs_cfg_if.sink       cfg
);

    localparam int AW = (BODY_COUNT > 1) ? $clog2(BODY_COUNT) : 1;
    localparam logic [5:0] LAST_STEP = 6'd50;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RDA   = 9'b000000010,
        S_RDB   = 9'b000000100,
        S_LDB   = 9'b000001000,
        S_CALC  = 9'b000010000,
        S_WRA   = 9'b000100000,
        S_WRB   = 9'b001000000,
        S_WRITE = 9'b010000000,
        S_RESP  = 9'b100000000
    } state_t;

    typedef enum logic [5:0] {
        R_NONE, R_ZERO, R_VAX, R_VAY, R_WA, R_MA, R_JA, R_VBX, R_VBY, R_WB, R_MB, R_JB,
        R_RAX, R_RAY, R_RBX, R_RBY, R_NX, R_NY, R_SEP, R_MASS, R_ACC, R_NACC, R_FRIC,
        R_INVH, R_BAUM, R_SLOP, R_MAXC, R_T0, R_T1, R_T2, R_T3, R_DIRX, R_DIRY,
        R_BIAS, R_LO, R_NEW, R_PX, R_PY
    } reg_t;

    typedef struct packed {
        cipgs_pkg::alu_op_t op;
        reg_t               a;
        reg_t               b;
        reg_t               dst;
    } micro_t;

    function automatic micro_t uop(input cipgs_pkg::alu_op_t op, input reg_t a,
                                   input reg_t b, input reg_t dst);
        micro_t m;
        m.op  = op;
        m.a   = a;
        m.b   = b;
        m.dst = dst;
        return m;
    endfunction

    function automatic micro_t micro(input logic [5:0] step, input logic fr,
                                     input logic sep_pos);
        micro_t m;
        m = uop(cipgs_pkg::OP_ADD, R_ZERO, R_ZERO, R_NONE);
        case (step)
            6'd0:  m = uop(cipgs_pkg::OP_MUL, R_WB, R_RBY, R_T0);
            6'd1:  m = uop(cipgs_pkg::OP_SUB, R_ZERO, R_T0, R_T0);
            6'd2:  m = uop(cipgs_pkg::OP_ADD, R_VBX, R_T0, R_T2);
            6'd3:  m = uop(cipgs_pkg::OP_MUL, R_WB, R_RBX, R_T0);
            6'd4:  m = uop(cipgs_pkg::OP_ADD, R_VBY, R_T0, R_T3);
            6'd5:  m = uop(cipgs_pkg::OP_MUL, R_WA, R_RAY, R_T0);
            6'd6:  m = uop(cipgs_pkg::OP_SUB, R_ZERO, R_T0, R_T0);
            6'd7:  m = uop(cipgs_pkg::OP_ADD, R_VAX, R_T0, R_T0);
            6'd8:  m = uop(cipgs_pkg::OP_MUL, R_WA, R_RAX, R_T1);
            6'd9:  m = uop(cipgs_pkg::OP_ADD, R_VAY, R_T1, R_T1);
            6'd10: m = uop(cipgs_pkg::OP_SUB, R_T2, R_T0, R_T2);
            6'd11: m = uop(cipgs_pkg::OP_SUB, R_T3, R_T1, R_T3);
            6'd12: m = fr ? uop(cipgs_pkg::OP_ADD, R_NY, R_ZERO, R_DIRX)
                          : uop(cipgs_pkg::OP_ADD, R_NX, R_ZERO, R_DIRX);
            6'd13: m = fr ? uop(cipgs_pkg::OP_SUB, R_ZERO, R_NX, R_DIRY)
                          : uop(cipgs_pkg::OP_ADD, R_NY, R_ZERO, R_DIRY);
            6'd14: m = fr ? uop(cipgs_pkg::OP_MUL, R_FRIC, R_NACC, R_BIAS)
                          : uop(cipgs_pkg::OP_ADD, R_SEP, R_SLOP, R_T0);
            6'd15: m = fr ? uop(cipgs_pkg::OP_SUB, R_ZERO, R_BIAS, R_LO)
                          : uop(cipgs_pkg::OP_MUL, R_BAUM, R_INVH, R_T1);
            6'd16: if (!fr) m = uop(cipgs_pkg::OP_MIN, R_T0, R_ZERO, R_T0);
            6'd17: if (!fr) m = uop(cipgs_pkg::OP_MUL, R_T1, R_T0, R_BIAS);
            6'd18: if (!fr) m = uop(cipgs_pkg::OP_SUB, R_ZERO, R_MAXC, R_LO);
            6'd19: if (!fr) m = uop(cipgs_pkg::OP_MAX, R_BIAS, R_LO, R_BIAS);
            6'd20: if (!fr && sep_pos) m = uop(cipgs_pkg::OP_MUL, R_SEP, R_INVH, R_BIAS);
            6'd21: m = uop(cipgs_pkg::OP_MUL, R_T2, R_DIRX, R_T0);
            6'd22: m = uop(cipgs_pkg::OP_MUL, R_T3, R_DIRY, R_T1);
            6'd23: m = uop(cipgs_pkg::OP_ADD, R_T0, R_T1, R_T0);
            6'd24: m = fr ? uop(cipgs_pkg::OP_SUB, R_ZERO, R_T0, R_T0)
                          : uop(cipgs_pkg::OP_ADD, R_T0, R_BIAS, R_T0);
            6'd25: m = uop(cipgs_pkg::OP_MUL, R_MASS, R_T0, R_T0);
            6'd26: if (!fr) m = uop(cipgs_pkg::OP_SUB, R_ZERO, R_T0, R_T0);
            6'd27: m = uop(cipgs_pkg::OP_ADD, R_ACC, R_T0, R_NEW);
            6'd28: m = fr ? uop(cipgs_pkg::OP_MIN, R_NEW, R_BIAS, R_NEW)
                          : uop(cipgs_pkg::OP_MAX, R_NEW, R_ZERO, R_NEW);
            6'd29: if (fr) m = uop(cipgs_pkg::OP_MAX, R_NEW, R_LO, R_NEW);
            6'd30: m = uop(cipgs_pkg::OP_SUB, R_NEW, R_ACC, R_T0);
            6'd31: m = uop(cipgs_pkg::OP_MUL, R_T0, R_DIRX, R_PX);
            6'd32: m = uop(cipgs_pkg::OP_MUL, R_T0, R_DIRY, R_PY);
            6'd33: m = uop(cipgs_pkg::OP_MUL, R_MA, R_PX, R_T0);
            6'd34: m = uop(cipgs_pkg::OP_SUB, R_VAX, R_T0, R_VAX);
            6'd35: m = uop(cipgs_pkg::OP_MUL, R_MA, R_PY, R_T0);
            6'd36: m = uop(cipgs_pkg::OP_SUB, R_VAY, R_T0, R_VAY);
            6'd37: m = uop(cipgs_pkg::OP_MUL, R_RAX, R_PY, R_T0);
            6'd38: m = uop(cipgs_pkg::OP_MUL, R_RAY, R_PX, R_T1);
            6'd39: m = uop(cipgs_pkg::OP_SUB, R_T0, R_T1, R_T0);
            6'd40: m = uop(cipgs_pkg::OP_MUL, R_JA, R_T0, R_T0);
            6'd41: m = uop(cipgs_pkg::OP_SUB, R_WA, R_T0, R_WA);
            6'd42: m = uop(cipgs_pkg::OP_MUL, R_MB, R_PX, R_T0);
            6'd43: m = uop(cipgs_pkg::OP_ADD, R_VBX, R_T0, R_VBX);
            6'd44: m = uop(cipgs_pkg::OP_MUL, R_MB, R_PY, R_T0);
            6'd45: m = uop(cipgs_pkg::OP_ADD, R_VBY, R_T0, R_VBY);
            6'd46: m = uop(cipgs_pkg::OP_MUL, R_RBX, R_PY, R_T0);
            6'd47: m = uop(cipgs_pkg::OP_MUL, R_RBY, R_PX, R_T1);
            6'd48: m = uop(cipgs_pkg::OP_SUB, R_T0, R_T1, R_T0);
            6'd49: m = uop(cipgs_pkg::OP_MUL, R_JB, R_T0, R_T0);
            6'd50: m = uop(cipgs_pkg::OP_ADD, R_WB, R_T0, R_WB);
            default: m = uop(cipgs_pkg::OP_ADD, R_ZERO, R_ZERO, R_NONE);
        endcase
        return m;
    endfunction

    state_t     state_reg, state_next;
    logic [5:0] step_reg, step_next;

    logic [30:0] inv_h_reg;
    logic [16:0] baum_reg;
    logic [30:0] slop_reg;
    logic [30:0] max_corr_reg;

    logic [1:0]  cmd_reg;
    logic [9:0]  ia_reg, ib_reg;
    logic signed [31:0] vax_reg, vay_reg, wa_reg, ma_reg, ja_reg;
    logic signed [31:0] vbx_reg, vby_reg, wb_reg, mb_reg, jb_reg;
    logic signed [31:0] rax_reg, ray_reg, rbx_reg, rby_reg, nx_reg, ny_reg;
    logic signed [31:0] sep_reg, mass_reg, acc_reg, nacc_reg, fric_reg;
    logic signed [31:0] t0_reg, t1_reg, t2_reg, t3_reg, dirx_reg, diry_reg;
    logic signed [31:0] bias_reg, lo_reg, new_reg, px_reg, py_reg;

    logic        oka, okb;
    logic        fric_cmd;
    micro_t      mc;
    logic signed [31:0] opa, opb, alu_y;
    logic        accept;

    logic        mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [cipgs_pkg::BODY_WORD_W-1:0] mem_wdata, mem_rdata;

    function automatic logic signed [31:0] pick(input reg_t r,
        input logic signed [31:0] vax, vay, wa, ma, ja, vbx, vby, wb, mb, jb,
        input logic signed [31:0] rax, ray, rbx, rby, nx, ny, sep, mass, acc, nacc, fr,
        input logic signed [31:0] invh, baum, slop, maxc, t0, t1, t2, t3, dx, dy,
        input logic signed [31:0] bias, lo, nw, px, py);
        logic signed [31:0] v;
        case (r)
            R_VAX:  v = vax;
            R_VAY:  v = vay;
            R_WA:   v = wa;
            R_MA:   v = ma;
            R_JA:   v = ja;
            R_VBX:  v = vbx;
            R_VBY:  v = vby;
            R_WB:   v = wb;
            R_MB:   v = mb;
            R_JB:   v = jb;
            R_RAX:  v = rax;
            R_RAY:  v = ray;
            R_RBX:  v = rbx;
            R_RBY:  v = rby;
            R_NX:   v = nx;
            R_NY:   v = ny;
            R_SEP:  v = sep;
            R_MASS: v = mass;
            R_ACC:  v = acc;
            R_NACC: v = nacc;
            R_FRIC: v = fr;
            R_INVH: v = invh;
            R_BAUM: v = baum;
            R_SLOP: v = slop;
            R_MAXC: v = maxc;
            R_T0:   v = t0;
            R_T1:   v = t1;
            R_T2:   v = t2;
            R_T3:   v = t3;
            R_DIRX: v = dx;
            R_DIRY: v = dy;
            R_BIAS: v = bias;
            R_LO:   v = lo;
            R_NEW:  v = nw;
            R_PX:   v = px;
            R_PY:   v = py;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign oka      = 32'(ia_reg) < BODY_COUNT;
    assign okb      = 32'(ib_reg) < BODY_COUNT;
    assign fric_cmd = (cmd_reg == cipgs_pkg::CMD_FRICTION);
    assign mc       = micro(step_reg, fric_cmd, sep_reg > 32'sd0);
    assign accept   = items.valid && items.ready;

    assign opa = pick(mc.a, vax_reg, vay_reg, wa_reg, ma_reg, ja_reg, vbx_reg, vby_reg,
        wb_reg, mb_reg, jb_reg, rax_reg, ray_reg, rbx_reg, rby_reg, nx_reg, ny_reg,
        sep_reg, mass_reg, acc_reg, nacc_reg, fric_reg, {1'b0, inv_h_reg},
        {15'd0, baum_reg}, {1'b0, slop_reg}, {1'b0, max_corr_reg}, t0_reg, t1_reg,
        t2_reg, t3_reg, dirx_reg, diry_reg, bias_reg, lo_reg, new_reg, px_reg, py_reg);
    assign opb = pick(mc.b, vax_reg, vay_reg, wa_reg, ma_reg, ja_reg, vbx_reg, vby_reg,
        wb_reg, mb_reg, jb_reg, rax_reg, ray_reg, rbx_reg, rby_reg, nx_reg, ny_reg,
        sep_reg, mass_reg, acc_reg, nacc_reg, fric_reg, {1'b0, inv_h_reg},
        {15'd0, baum_reg}, {1'b0, slop_reg}, {1'b0, max_corr_reg}, t0_reg, t1_reg,
        t2_reg, t3_reg, dirx_reg, diry_reg, bias_reg, lo_reg, new_reg, px_reg, py_reg);

    cipgs_alu u_alu (
        .op (mc.op),
        .a  (opa),
        .b  (opb),
        .y  (alu_y)
    );

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = AW'(ia_reg);
        mem_wdata = {rax_reg, ray_reg, sep_reg, mass_reg, fric_reg};
        mem_raddr = AW'(ia_reg);
        case (state_reg)
            S_RDB:   mem_raddr = AW'(ib_reg);
            S_WRITE: mem_we = oka;
            S_WRA:
            begin
                mem_we    = oka;
                mem_wdata = {vax_reg, vay_reg, wa_reg, ma_reg, ja_reg};
            end
            S_WRB:
            begin
                mem_we    = okb;
                mem_waddr = AW'(ib_reg);
                mem_wdata = {vbx_reg, vby_reg, wb_reg, mb_reg, jb_reg};
            end
            default: ;
        endcase
    end

    cipgs_body_mem #(
        .DEPTH (BODY_COUNT),
        .AW    (AW)
    ) u_body_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = (items.cmd == cipgs_pkg::CMD_WRITE) ? S_WRITE : S_RDA;
            end
            S_RDA:   state_next = S_RDB;
            S_RDB:   state_next = (cmd_reg == cipgs_pkg::CMD_READ) ? S_RESP : S_LDB;
            S_LDB:
            begin
                state_next = S_CALC;
                step_next  = '0;
            end
            S_CALC:
            begin
                if (step_reg == LAST_STEP)
                    state_next = S_WRA;
                else
                    step_next = step_reg + 6'd1;
            end
            S_WRA:   state_next = S_WRB;
            S_WRB:   state_next = S_RESP;
            S_WRITE: state_next = S_RESP;
            S_RESP:
            begin
                if (results.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            inv_h_reg    <= 31'd3932160;
            baum_reg     <= 17'd13107;
            slop_reg     <= 31'd328;
            max_corr_reg <= 31'd262144;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    cipgs_pkg::CFG_INV_H:    inv_h_reg    <= cfg.data[30:0];
                    cipgs_pkg::CFG_BAUM:     baum_reg     <= cfg.data[16:0];
                    cipgs_pkg::CFG_SLOP:     slop_reg     <= cfg.data[30:0];
                    cipgs_pkg::CFG_MAX_CORR: max_corr_reg <= cfg.data[30:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= items.cmd;
            ia_reg   <= items.body_a;
            ib_reg   <= items.body_b;
            nx_reg   <= items.normal_dir[63:32];
            ny_reg   <= items.normal_dir[31:0];
            rax_reg  <= items.anchor_a[63:32];
            ray_reg  <= items.anchor_a[31:0];
            rbx_reg  <= items.anchor_b[63:32];
            rby_reg  <= items.anchor_b[31:0];
            sep_reg  <= items.separation;
            mass_reg <= items.effective_mass;
            acc_reg  <= items.accumulated_in;
            nacc_reg <= items.normal_accumulated;
            fric_reg <= items.friction_coef;
        end
        if (state_reg == S_RDB)
        begin
            vax_reg <= oka ? mem_rdata[159:128] : '0;
            vay_reg <= oka ? mem_rdata[127:96]  : '0;
            wa_reg  <= oka ? mem_rdata[95:64]   : '0;
            ma_reg  <= oka ? mem_rdata[63:32]   : '0;
            ja_reg  <= oka ? mem_rdata[31:0]    : '0;
        end
        if (state_reg == S_LDB)
        begin
            vbx_reg <= okb ? mem_rdata[159:128] : '0;
            vby_reg <= okb ? mem_rdata[127:96]  : '0;
            wb_reg  <= okb ? mem_rdata[95:64]   : '0;
            mb_reg  <= okb ? mem_rdata[63:32]   : '0;
            jb_reg  <= okb ? mem_rdata[31:0]    : '0;
        end
        if (state_reg == S_CALC)
        begin
            case (mc.dst)
                R_VAX:  vax_reg  <= alu_y;
                R_VAY:  vay_reg  <= alu_y;
                R_WA:   wa_reg   <= alu_y;
                R_VBX:  vbx_reg  <= alu_y;
                R_VBY:  vby_reg  <= alu_y;
                R_WB:   wb_reg   <= alu_y;
                R_T0:   t0_reg   <= alu_y;
                R_T1:   t1_reg   <= alu_y;
                R_T2:   t2_reg   <= alu_y;
                R_T3:   t3_reg   <= alu_y;
                R_DIRX: dirx_reg <= alu_y;
                R_DIRY: diry_reg <= alu_y;
                R_BIAS: bias_reg <= alu_y;
                R_LO:   lo_reg   <= alu_y;
                R_NEW:  new_reg  <= alu_y;
                R_PX:   px_reg   <= alu_y;
                R_PY:   py_reg   <= alu_y;
                default: ;
            endcase
        end
    end

    assign items.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    assign results.valid            = (state_reg == S_RESP);
    assign results.accumulated_out  = (cmd_reg == cipgs_pkg::CMD_NORMAL ||
                                       cmd_reg == cipgs_pkg::CMD_FRICTION) ? new_reg : '0;
    assign results.linear_velocity  = (cmd_reg == cipgs_pkg::CMD_READ) ?
                                      {vax_reg, vay_reg} : '0;
    assign results.angular_velocity = (cmd_reg == cipgs_pkg::CMD_READ) ? wa_reg : '0;

endmodule

// File: sv/cipgs_alu.sv
// ----------------------------------------------------------------------------
// cipgs_alu
// Shared saturating Q16.16 unit: multiply, add, subtract, max, min.
// ----------------------------------------------------------------------------
module cipgs_alu (
    input  cipgs_pkg::alu_op_t op,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] y
);

    localparam logic signed [31:0] QMAX = 32'sh7fffffff;
    localparam logic signed [31:0] QMIN = 32'sh80000000;

    logic signed [63:0] prod;
    logic signed [47:0] prod_sh;
    logic signed [32:0] sum;
    logic signed [32:0] diff;

    assign prod    = a * b;
    assign prod_sh = prod[63:16];
    assign sum     = 33'(a) + 33'(b);
    assign diff    = 33'(a) - 33'(b);

    always_comb
    begin
        case (op)
            cipgs_pkg::OP_MUL:
            begin
                if (prod_sh > 48'(QMAX))
                    y = QMAX;
                else if (prod_sh < 48'(QMIN))
                    y = QMIN;
                else
                    y = prod_sh[31:0];
            end
            cipgs_pkg::OP_ADD:
            begin
                if (sum > 33'(QMAX))
                    y = QMAX;
                else if (sum < 33'(QMIN))
                    y = QMIN;
                else
                    y = sum[31:0];
            end
            cipgs_pkg::OP_SUB:
            begin
                if (diff > 33'(QMAX))
                    y = QMAX;
                else if (diff < 33'(QMIN))
                    y = QMIN;
                else
                    y = diff[31:0];
            end
            cipgs_pkg::OP_MAX: y = (a > b) ? a : b;
            cipgs_pkg::OP_MIN: y = (a < b) ? a : b;
            default:           y = '0;
        endcase
    end

endmodule

// File: sv/cipgs_body_mem.sv
// ----------------------------------------------------------------------------
// cipgs_body_mem
// Body table: one word per body, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cipgs_body_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [AW-1:0]                         waddr,
    input  logic [cipgs_pkg::BODY_WORD_W-1:0]     wdata,
    input  logic [AW-1:0]                         raddr,
    output logic [cipgs_pkg::BODY_WORD_W-1:0]     rdata
);

    logic [cipgs_pkg::BODY_WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: test/contact_impulse_pgs_solver_test.sv
// ----------------------------------------------------------------------------
// contact_impulse_pgs_solver_test
// Self-checking bench for the contact solver: a directed table, then random
// body loads, normal and friction solves and reads, each result word checked
// against an in-bench Q16.16 predictor, under random source gaps and sink
// stalls, with configuration changed between phases.
// ----------------------------------------------------------------------------
module contact_impulse_pgs_solver_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBODY = 1024;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [31:0] acc;
        logic [63:0]        lin;
        logic signed [31:0] ang;
    } solve_word_t;

    typedef struct {
        cipgs_pkg::cmd_t    cmd;
        logic [9:0]         a;
        logic [9:0]         b;
        logic [63:0]        n;
        logic [63:0]        ra;
        logic [63:0]        rb;
        logic signed [31:0] sep;
        logic signed [31:0] mass;
        logic signed [31:0] acc;
        logic signed [31:0] nacc;
        logic signed [31:0] fric;
        bit                 typed;
        solve_word_t        want;
    } item_row_t;

    logic clk;
    logic rst_n;

    cipgs_item_if   items ();
    cipgs_result_if results ();
    cipgs_cfg_if    cfg ();

    contact_impulse_pgs_solver u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .cfg     (cfg)
    );

    logic [63:0]        tbl_lin [NBODY];
    logic signed [31:0] tbl_ang [NBODY];
    logic signed [31:0] tbl_im  [NBODY];
    logic signed [31:0] tbl_ii  [NBODY];
    bit                 tbl_set [NBODY];
    logic [31:0] r_inv_h, r_baum, r_slop, r_maxc;

    solve_word_t expected_words[$];
    int errors;
    int idle_cycles;
    bit stall_on;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_add(input logic signed [31:0] a, b);
        return sat64(64'(a) + 64'(b));
    endfunction

    function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a, b);
        return sat64(64'(a) - 64'(b));
    endfunction

    function automatic logic signed [31:0] fx_neg(input logic signed [31:0] a);
        return sat64(-64'(a));
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a, b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat64(p >>> 16);
    endfunction

    function automatic logic signed [31:0] hi(input logic [63:0] v);
        return v[63:32];
    endfunction

    function automatic logic signed [31:0] lo(input logic [63:0] v);
        return v[31:0];
    endfunction

    function automatic solve_word_t solve_contact(input item_row_t it);
        solve_word_t w;
        logic signed [31:0] vax, vay, wa, ma, ja, vbx, vby, wb, mb, jb;
        logic signed [31:0] pax, pay, pbx, pby, dvx, dvy, dx, dy, rel, imp, nimp;
        logic signed [31:0] bias, t, lim, bound, lob, delta, px, py;
        w = '0;
        if (it.cmd == cipgs_pkg::CMD_WRITE)
        begin
            tbl_lin[it.a] = it.ra;
            tbl_ang[it.a] = it.sep;
            tbl_im[it.a] = it.mass;
            tbl_ii[it.a] = it.fric;
            tbl_set[it.a] = 1'b1;
            return w;
        end
        if (it.cmd == cipgs_pkg::CMD_READ)
        begin
            w.lin = tbl_lin[it.a];
            w.ang = tbl_ang[it.a];
            return w;
        end
        vax = hi(tbl_lin[it.a]); vay = lo(tbl_lin[it.a]);
        wa = tbl_ang[it.a]; ma = tbl_im[it.a]; ja = tbl_ii[it.a];
        vbx = hi(tbl_lin[it.b]); vby = lo(tbl_lin[it.b]);
        wb = tbl_ang[it.b]; mb = tbl_im[it.b]; jb = tbl_ii[it.b];
        pbx = fx_add(vbx, fx_neg(fx_mul(wb, lo(it.rb))));
        pby = fx_add(vby, fx_mul(wb, hi(it.rb)));
        pax = fx_add(vax, fx_neg(fx_mul(wa, lo(it.ra))));
        pay = fx_add(vay, fx_mul(wa, hi(it.ra)));
        dvx = fx_sub(pbx, pax);
        dvy = fx_sub(pby, pay);
        if (it.cmd == cipgs_pkg::CMD_NORMAL)
        begin
            dx = hi(it.n); dy = lo(it.n);
            if (it.sep > 0)
                bias = fx_mul(it.sep, r_inv_h);
            else
            begin
                t = fx_add(it.sep, r_slop);
                lim = -$signed(r_maxc);
                if (t > 0) t = 0;
                bias = fx_mul(fx_mul(r_baum, r_inv_h), t);
                if (bias < lim) bias = lim;
            end
            rel = fx_add(fx_mul(dvx, dx), fx_mul(dvy, dy));
            imp = fx_neg(fx_mul(it.mass, fx_add(rel, bias)));
            nimp = fx_add(it.acc, imp);
            if (nimp < 0) nimp = 0;
        end
        else
        begin
            bound = fx_mul(it.fric, it.nacc);
            lob = fx_neg(bound);
            dx = lo(it.n); dy = fx_neg(hi(it.n));
            rel = fx_add(fx_mul(dvx, dx), fx_mul(dvy, dy));
            imp = fx_mul(it.mass, fx_neg(rel));
            nimp = fx_add(it.acc, imp);
            if (nimp > bound) nimp = bound;
            if (nimp < lob) nimp = lob;
        end
        delta = fx_sub(nimp, it.acc);
        px = fx_mul(delta, dx);
        py = fx_mul(delta, dy);
        vax = fx_sub(vax, fx_mul(ma, px));
        vay = fx_sub(vay, fx_mul(ma, py));
        wa = fx_sub(wa, fx_mul(ja, fx_sub(fx_mul(hi(it.ra), py), fx_mul(lo(it.ra), px))));
        vbx = fx_add(vbx, fx_mul(mb, px));
        vby = fx_add(vby, fx_mul(mb, py));
        wb = fx_add(wb, fx_mul(jb, fx_sub(fx_mul(hi(it.rb), py), fx_mul(lo(it.rb), px))));
        tbl_lin[it.a] = {vax, vay}; tbl_ang[it.a] = wa;
        tbl_lin[it.b] = {vbx, vby}; tbl_ang[it.b] = wb;
        w.acc = nimp;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got, want);
        $display("%0t: %s got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    // result check and sink stalls
    always @(posedge clk)
    begin
        solve_word_t w;
        if (rst_n && results.valid && results.ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word", results.accumulated_out, 0);
            else
            begin
                w = expected_words.pop_front();
                if (results.accumulated_out !== w.acc)
                    report_mismatch("accumulated_out", results.accumulated_out, w.acc);
                if (results.linear_velocity !== w.lin)
                    report_mismatch("linear_velocity", results.linear_velocity, w.lin);
                if (results.angular_velocity !== w.ang)
                    report_mismatch("angular_velocity", results.angular_velocity, w.ang);
            end
        end
    end

    always @(negedge clk)
    begin
        if ($urandom_range(0, 99) < 3) stall_on = ~stall_on;
        results.ready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("contact_impulse_pgs_solver: mismatch");
            $finish;
        end
    end

    task automatic send_item(input item_row_t it);
        solve_word_t w;
        items.valid <= 1'b1;
        items.cmd <= it.cmd;
        items.body_a <= it.a;
        items.body_b <= it.b;
        items.normal_dir <= it.n;
        items.anchor_a <= it.ra;
        items.anchor_b <= it.rb;
        items.separation <= it.sep;
        items.effective_mass <= it.mass;
        items.accumulated_in <= it.acc;
        items.normal_accumulated <= it.nacc;
        items.friction_coef <= it.fric;
        do @(posedge clk); while (!items.ready);
        w = solve_contact(it);
        if (it.typed)
        begin
            if (w.acc !== it.want.acc)
                report_mismatch("typed accumulated_out", w.acc, it.want.acc);
            if (w.lin !== it.want.lin)
                report_mismatch("typed linear_velocity", w.lin, it.want.lin);
            if (w.ang !== it.want.ang)
                report_mismatch("typed angular_velocity", w.ang, it.want.ang);
        end
        expected_words.push_back(w);
        @(negedge clk);
    endtask

    task automatic gap();
        items.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
    endtask

    task automatic write_reg(input cipgs_pkg::cfg_idx_t idx, input logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            cipgs_pkg::CFG_INV_H:    r_inv_h = val & 32'h7fffffff;
            cipgs_pkg::CFG_BAUM:     r_baum = val & 32'h1ffff;
            cipgs_pkg::CFG_SLOP:     r_slop = val & 32'h7fffffff;
            cipgs_pkg::CFG_MAX_CORR: r_maxc = val & 32'h7fffffff;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic drain();
        items.valid <= 1'b0;
        while (expected_words.size() != 0) @(negedge clk);
        repeat (70) @(negedge clk);
    endtask

    function automatic logic [31:0] rnd_q();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return $signed($urandom_range(0, 262144)) - 131072;
        endcase
    endfunction

    function automatic item_row_t rnd_item(input int kind, input int nb);
        item_row_t it;
        it.cmd = cipgs_pkg::cmd_t'(kind);
        it.a = 10'($urandom_range(0, nb - 1));
        it.b = 10'($urandom_range(0, nb - 1));
        it.n = {rnd_q(), rnd_q()};
        it.ra = {rnd_q(), rnd_q()};
        it.rb = {rnd_q(), rnd_q()};
        it.sep = rnd_q();
        it.mass = rnd_q();
        it.acc = rnd_q();
        it.nacc = rnd_q();
        it.fric = rnd_q();
        it.typed = 0;
        it.want = '0;
        return it;
    endfunction

    initial
    begin
        item_row_t dir_rows[$];
        item_row_t it;
        int nb;
        int k;
        errors = 0;
        idle_cycles = 0;
        stall_on = 0;
        r_inv_h = 3932160; r_baum = 13107; r_slop = 328; r_maxc = 262144;
        for (int i = 0; i < NBODY; i++)
        begin
            tbl_lin[i] = '0; tbl_ang[i] = 0; tbl_im[i] = 0; tbl_ii[i] = 0; tbl_set[i] = 0;
        end
        rst_n = 1'b0;
        items.valid = 1'b0;
        items.cmd = cipgs_pkg::CMD_NORMAL;
        items.body_a = '0; items.body_b = '0;
        items.normal_dir = '0; items.anchor_a = '0; items.anchor_b = '0;
        items.separation = '0; items.effective_mass = '0; items.accumulated_in = '0;
        items.normal_accumulated = '0; items.friction_coef = '0;
        results.ready = 1'b0;
        cfg.valid = 1'b0; cfg.index = cipgs_pkg::CFG_INV_H; cfg.data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table: loads at extremes, reads, solves incl. same body, bias paths
        it = rnd_item(cipgs_pkg::CMD_WRITE, 1);
        it.a = 0; it.ra = 64'h7fffffff_80000000; it.sep = 32'sh7fffffff;
        it.mass = 32'sh80000000; it.fric = 32'sh7fffffff;
        dir_rows.push_back(it);
        it.a = 1023; it.ra = 64'hffffffff_00000000; it.sep = 32'sh80000000;
        it.mass = 32'sh7fffffff; it.fric = 32'sh80000000;
        dir_rows.push_back(it);
        it.a = 1; it.ra = 64'h00010000_00020000; it.sep = 32'sh00008000;
        it.mass = 32'sh00010000; it.fric = 32'sh00004000;
        dir_rows.push_back(it);
        it = rnd_item(cipgs_pkg::CMD_READ, 1); it.a = 0; it.typed = 1;
        it.want = '{acc: 0, lin: 64'h7fffffff_80000000, ang: 32'sh7fffffff};
        dir_rows.push_back(it);
        it.a = 1023;
        it.want = '{acc: 0, lin: 64'hffffffff_00000000, ang: 32'sh80000000};
        dir_rows.push_back(it);
        for (int s = 0; s < 3; s++)
        begin
            it = rnd_item(cipgs_pkg::CMD_NORMAL, 1);
            it.a = 1; it.b = (s == 0) ? 1 : 0;
            it.sep = (s == 1) ? 32'sh00010000 : -32'sh00020000;
            dir_rows.push_back(it);
            it.sep = 32'sh80000000; it.a = 0; it.b = 1023;
            dir_rows.push_back(it);
            it = rnd_item(cipgs_pkg::CMD_FRICTION, 1);
            it.a = 1; it.b = 0; it.fric = -32'sh00008000; it.nacc = 32'sh00010000;
            dir_rows.push_back(it);
            it.a = 1023; it.b = 1023; it.fric = 32'sh7fffffff; it.nacc = 32'sh80000000;
            dir_rows.push_back(it);
        end
        it = rnd_item(cipgs_pkg::CMD_NORMAL, 1);
        it.a = 0; it.b = 1; it.n = '1; it.ra = '1; it.rb = '0;
        it.acc = 32'sh80000000; it.mass = 32'sh7fffffff;
        dir_rows.push_back(it);
        it = rnd_item(cipgs_pkg::CMD_READ, 1); it.a = 1;
        dir_rows.push_back(it);
        foreach (dir_rows[i])
            send_item(dir_rows[i]);
        drain();

        write_reg(cipgs_pkg::CFG_INV_H, 32'h7fffffff);
        write_reg(cipgs_pkg::CFG_BAUM, 32'h00010000);
        write_reg(cipgs_pkg::CFG_SLOP, 32'h00000000);
        write_reg(cipgs_pkg::CFG_MAX_CORR, 32'h7fffffff);
        cfg.valid <= 1'b0;

        // random phases: load bodies first so every solve reads written state
        for (int phase = 0; phase < 4; phase++)
        begin
            nb = (phase == 2) ? NBODY : $urandom_range(2, 12);
            for (int i = 0; i < nb; i++)
                if (!tbl_set[i])
                begin
                    it = rnd_item(cipgs_pkg::CMD_WRITE, 1);
                    it.a = 10'(i);
                    send_item(it);
                end
            k = 0;
            while (k < 225)
            begin
                if ($urandom_range(0, 99) < 30) gap();
                repeat ($urandom_range(1, 12))
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: it = rnd_item(cipgs_pkg::CMD_NORMAL, nb);
                        4, 5, 6:    it = rnd_item(cipgs_pkg::CMD_FRICTION, nb);
                        7:          it = rnd_item(cipgs_pkg::CMD_WRITE, nb);
                        default:    it = rnd_item(cipgs_pkg::CMD_READ, nb);
                    endcase
                    send_item(it);
                    k++;
                end
            end
            drain();
            write_reg(cipgs_pkg::CFG_INV_H, (phase == 0) ? 32'h0 : $urandom());
            write_reg(cipgs_pkg::CFG_BAUM, (phase == 1) ? 32'h0 : $urandom_range(0, 65536));
            write_reg(cipgs_pkg::CFG_SLOP,
                      (phase == 1) ? 32'h7fffffff : $urandom_range(0, 65536));
            write_reg(cipgs_pkg::CFG_MAX_CORR, (phase == 0) ? 32'h0 : $urandom());
            cfg.valid <= 1'b0;
        end
        drain();

        if (errors == 0)
            $display("contact_impulse_pgs_solver: match");
        else
            $display("contact_impulse_pgs_solver: mismatch");
        $finish;
    end

endmodule

// File: files.f
sv/cipgs_pkg.sv
sv/cipgs_if.sv
sv/cipgs_alu.sv
sv/cipgs_body_mem.sv
sv/contact_impulse_pgs_solver.sv
test/contact_impulse_pgs_solver_test.sv
